// ----- hdl/cpk_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants of the 15-bit coefficient pack codec
package cpk_pkg;

  localparam int unsigned NUM_COEFFS = 2592;
  localparam int unsigned COEFF_BITS = 15;
  localparam int unsigned POLY_LEN   = NUM_COEFFS / 8 * 8;

  localparam int unsigned BUF_W   = 22;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned ITEM_W  = 13;
  localparam int unsigned COEF_W  = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 15;

  localparam logic [COEFF_BITS-1:0] MODULUS_RESET = 15'd7681;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODULUS   = 1'b0,
    REG_DIRECTION = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    DIR_PACK   = 1'b0,
    DIR_UNPACK = 1'b1
  } dir_e;

  typedef struct packed {
    logic [COEFF_BITS-1:0] modulus;
    dir_e                  direction;
    logic                  clear;
  } ctrl_t;

  typedef struct packed {
    logic [BYTE_W-1:0]     byte_out;
    logic [COEFF_BITS-1:0] coeff_out;
    logic                  run_last;
    logic                  poly_done;
  } res_t;

  typedef struct packed {
    res_t r0;
    res_t r1;
    logic two;
  } job_t;

endpackage

// ----- hdl/cpk_if.sv -----
`timescale 1ns / 1ps
// channel interfaces of the coefficient pack codec
interface cpk_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [cpk_pkg::COEF_W-1:0] coefficient;
  logic [cpk_pkg::BYTE_W-1:0]      byte_in;
  modport source (output valid, coefficient, byte_in, input ready);
  modport sink (input valid, coefficient, byte_in, output ready);
endinterface

interface cpk_out_if;
  logic                              valid;
  logic                              ready;
  logic [cpk_pkg::BYTE_W-1:0]        byte_out;
  logic [cpk_pkg::COEFF_BITS-1:0]    coeff_out;
  logic                              run_last;
  logic                              poly_done;
  modport source (output valid, byte_out, coeff_out, run_last, poly_done, input ready);
  modport sink (input valid, byte_out, coeff_out, run_last, poly_done, output ready);
endinterface

interface cpk_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [cpk_pkg::CFG_IDX_W-1:0]     index;
  logic [cpk_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/cpk_front.sv -----
`timescale 1ns / 1ps
// front end: accepts items, updates the bit buffer and forms result jobs
module cpk_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  cpk_in_if.sink               item_in_i,
  input  cpk_pkg::ctrl_t       ctrl_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output cpk_pkg::job_t        job_o
);

  logic [cpk_pkg::BUF_W-1:0]      buf_q, buf_d;
  logic [cpk_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic [cpk_pkg::ITEM_W-1:0]     items_q, items_d;

  logic                           accept;
  logic                           final_item;
  logic [cpk_pkg::COEF_W-1:0]     raw;
  logic [cpk_pkg::COEF_W-1:0]     pk_sum;
  logic [cpk_pkg::COEFF_BITS-1:0] pk_val;
  logic [cpk_pkg::BUF_W-1:0]      pk_merged;
  logic [cpk_pkg::CNT_W-1:0]      pk_total;
  logic                           pk_two;
  logic [3:0]                     up_shift;
  logic [cpk_pkg::BUF_W-1:0]      up_merged;
  logic [cpk_pkg::CNT_W-1:0]      up_total;
  logic                           up_hit;

  assign item_in_i.ready = !q_full_i;
  assign accept = item_in_i.valid && item_in_i.ready;
  assign final_item = items_q >= cpk_pkg::ITEM_W'(cpk_pkg::POLY_LEN - 1);

  // pack path
  assign raw       = item_in_i.coefficient;
  assign pk_sum    = raw[cpk_pkg::COEF_W-1] ? raw + {1'b0, ctrl_i.modulus} : raw;
  assign pk_val    = pk_sum[cpk_pkg::COEFF_BITS-1:0];
  assign pk_merged = buf_q | (cpk_pkg::BUF_W'(pk_val) << cnt_q[2:0]);
  assign pk_total  = {2'b00, cnt_q[2:0]} + 5'd15;
  assign pk_two    = pk_total >= 5'd16;

  // unpack path
  assign up_shift  = (cnt_q > 5'd14) ? 4'd14 : cnt_q[3:0];
  assign up_merged = buf_q | (cpk_pkg::BUF_W'(item_in_i.byte_in) << up_shift);
  assign up_total  = {1'b0, up_shift} + 5'd8;
  assign up_hit    = up_total >= 5'd15;

  always_comb begin
    buf_d   = buf_q;
    cnt_d   = cnt_q;
    items_d = items_q;
    push_o  = 1'b0;
    job_o   = '0;
    case (ctrl_i.direction)
      cpk_pkg::DIR_PACK: begin
        push_o = accept;
        job_o.two          = pk_two;
        job_o.r0.byte_out  = pk_merged[7:0];
        job_o.r0.run_last  = !pk_two;
        job_o.r0.poly_done = !pk_two && final_item;
        job_o.r1.byte_out  = pk_merged[15:8];
        job_o.r1.run_last  = 1'b1;
        job_o.r1.poly_done = final_item;
        if (accept) begin
          buf_d   = pk_two ? (pk_merged >> 16) : (pk_merged >> 8);
          cnt_d   = pk_two ? pk_total - 5'd16 : pk_total - 5'd8;
          items_d = items_q + 1'b1;
        end
      end
      cpk_pkg::DIR_UNPACK: begin
        push_o = accept && up_hit;
        job_o.r0.coeff_out = up_merged[cpk_pkg::COEFF_BITS-1:0];
        job_o.r0.run_last  = 1'b1;
        job_o.r0.poly_done = final_item;
        if (accept) begin
          if (up_hit) begin
            buf_d   = up_merged >> cpk_pkg::COEFF_BITS;
            cnt_d   = up_total - 5'd15;
            items_d = items_q + 1'b1;
          end else begin
            buf_d = up_merged;
            cnt_d = up_total;
          end
        end
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
    // end of polynomial or any direction write restarts the stream
    if ((push_o && final_item) || ctrl_i.clear) begin
      buf_d   = '0;
      cnt_d   = '0;
      items_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q   <= '0;
      cnt_q   <= '0;
      items_q <= '0;
    end else begin
      buf_q   <= buf_d;
      cnt_q   <= cnt_d;
      items_q <= items_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 5'd14)
    else $error("bit count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.direction == cpk_pkg::DIR_PACK) && !ctrl_i.clear |-> cnt_q <= 5'd7)
    else $error("pack bit count not below one byte");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    items_q < cpk_pkg::ITEM_W'(cpk_pkg::POLY_LEN))
    else $error("item count past polynomial end");

endmodule

// ----- hdl/cpk_queue.sv -----
`timescale 1ns / 1ps
// two-entry job queue between front and back end
module cpk_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cpk_pkg::job_t  job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output cpk_pkg::job_t  job_o
);

  cpk_pkg::job_t entries_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign job_o   = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= 2'd2)
    else $error("queue count overflow");

endmodule

// ----- hdl/cpk_back.sv -----
`timescale 1ns / 1ps
// back end: splits jobs into result items behind an output register
module cpk_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  cpk_pkg::job_t  q_job_i,
  output logic           q_pop_o,
  cpk_out_if.source      item_out_o
);

  cpk_pkg::res_t out_q, out_d;
  cpk_pkg::res_t pend_q, pend_d;
  logic          out_valid_q, out_valid_d;
  logic          pend_valid_q, pend_valid_d;
  logic          load;

  assign load = !out_valid_q || item_out_o.ready;

  always_comb begin
    out_d        = out_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q;
    pend_valid_d = pend_valid_q;
    q_pop_o      = 1'b0;
    if (load) begin
      if (pend_valid_q) begin
        out_d        = pend_q;
        out_valid_d  = 1'b1;
        pend_valid_d = 1'b0;
      end else if (q_valid_i) begin
        q_pop_o      = 1'b1;
        out_d        = q_job_i.r0;
        out_valid_d  = 1'b1;
        pend_d       = q_job_i.r1;
        pend_valid_d = q_job_i.two;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  assign item_out_o.valid     = out_valid_q;
  assign item_out_o.byte_out  = out_q.byte_out;
  assign item_out_o.coeff_out = out_q.coeff_out;
  assign item_out_o.run_last  = out_q.run_last;
  assign item_out_o.poly_done = out_q.poly_done;

  assert property (@(posedge clk_i) disable iff (!rst_ni) pend_valid_q |-> out_valid_q)
    else $error("second byte pending without first");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q && !load |=> pend_valid_q)
    else $error("pending byte lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> !out_q.run_last)
    else $error("item end flagged before its last result");

endmodule

// ----- hdl/coeff_pack15_codec_unit.sv -----
`timescale 1ns / 1ps
// top level of the 15-bit coefficient pack/unpack codec
//
// channels: item_in_i takes a signed coefficient (pack) or a byte (unpack),
// item_out_o gives each result on its own handshake, cfg_i writes
// register 0 (modulus) or register 1 (direction); any direction write
// restarts the bit stream. cfg_i is always ready.
// pack mode: each coefficient gives one or two bytes, unpack mode: a byte
// gives at most one coefficient; run_last marks an item's last result and
// poly_done the final result of the polynomial.
// path: the first result of an item is registered in the job queue and
// then in the output register, a second byte waits in a pending register.
// throughput: one item per cycle in while the job queue has room, one result
// per cycle out while item_out_o.ready is high; pack mode is limited by the
// output for coefficients of two bytes, unpack mode at one byte per cycle.
// a two-entry job queue sits between front end and back end, so input keeps
// flowing while a result waits; when the receiver stalls the queue fills and
// item_in_i.ready drops.
// reset: modulus 7681, pack mode, empty bit buffer, nothing pending.
module coeff_pack15_codec_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  cpk_in_if.sink      item_in_i,
  cpk_out_if.source   item_out_o,
  cpk_cfg_if.sink     cfg_i
);

  logic [cpk_pkg::COEFF_BITS-1:0] modulus_q;
  cpk_pkg::dir_e                  direction_q;
  cpk_pkg::ctrl_t                 ctrl;
  cpk_pkg::job_t                  push_job, pop_job;
  logic                           push, pop, q_full, q_valid;
  logic                           cfg_wr;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q   <= cpk_pkg::MODULUS_RESET;
      direction_q <= cpk_pkg::DIR_PACK;
    end else if (cfg_wr) begin
      if (cfg_i.index == cpk_pkg::REG_MODULUS) begin
        modulus_q <= cfg_i.data[cpk_pkg::COEFF_BITS-1:0];
      end else if (cfg_i.index == cpk_pkg::REG_DIRECTION) begin
        direction_q <= cpk_pkg::dir_e'(cfg_i.data[0]);
      end
    end
  end

  assign ctrl.modulus   = modulus_q;
  assign ctrl.direction = direction_q;
  assign ctrl.clear     = cfg_wr && (cfg_i.index == cpk_pkg::REG_DIRECTION);

  cpk_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_in_i (item_in_i),
    .ctrl_i    (ctrl),
    .q_full_i  (q_full),
    .push_o    (push),
    .job_o     (push_job)
  );

  cpk_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (pop_job)
  );

  cpk_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_job_i    (pop_job),
    .q_pop_o    (pop),
    .item_out_o (item_out_o)
  );

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// self-checking testbench of the 15-bit coefficient pack/unpack codec
module testbench;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 7;
  localparam int NUM_ITEMS    = 1850;
  localparam int SETTLE_WAIT  = 12;
  localparam int STALL_CYCLES = 400;
  localparam int WDOG_LIMIT   = 4000;
  localparam int MAX_REPORTS  = 40;

  typedef struct {
    logic signed [cpk_pkg::COEF_W-1:0] coef;
    logic [cpk_pkg::BYTE_W-1:0]        bin;
  } feed_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;

  cpk_in_if  in_ch ();
  cpk_out_if out_ch ();
  cpk_cfg_if cfg_ch ();

  coeff_pack15_codec_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .item_in_i  (in_ch),
    .item_out_o (out_ch),
    .cfg_i      (cfg_ch)
  );

  always #(CLK_HALF) clk = ~clk;

  // stream model state and register copies
  logic [cpk_pkg::COEFF_BITS-1:0] mod_q  = cpk_pkg::MODULUS_RESET;
  cpk_pkg::dir_e                  dir_q  = cpk_pkg::DIR_PACK;
  logic [cpk_pkg::BUF_W-1:0]      sbuf   = '0;
  logic [cpk_pkg::CNT_W-1:0]      scnt   = '0;
  logic [cpk_pkg::ITEM_W-1:0]     nitems = '0;

  feed_t         feed_q [$];
  cpk_pkg::res_t stream_results_q [$];
  feed_t         cur;
  cpk_pkg::res_t want;

  bit in_fire    = 1'b0;
  bit idle_on    = 1'b1;
  bit stall_req  = 1'b0;
  int stall_left = 0;
  int tx_gap     = 0;
  int rx_gap     = 0;
  int quiet      = 0;
  int n_err      = 0;
  int n_items    = 0;
  int n_packed   = 0;
  int n_unpacked = 0;
  int n_results  = 0;
  int n_done     = 0;
  int n_cfg      = 0;

  function automatic void restart_stream();
    sbuf   = '0;
    scnt   = '0;
    nitems = '0;
  endfunction

  task automatic advance_stream(input logic signed [cpk_pkg::COEF_W-1:0] coef,
                                input logic [cpk_pkg::BYTE_W-1:0] bin);
    logic [cpk_pkg::COEFF_BITS-1:0] v;
    logic [cpk_pkg::CNT_W-1:0]      cnt;
    logic                           fin;
    cpk_pkg::res_t                  burst [2];
    int                             n;
    begin
      fin = (32'(nitems) + 32'd1 >= cpk_pkg::POLY_LEN);
      n = 0;
      if (dir_q == cpk_pkg::DIR_PACK) begin
        v = coef[cpk_pkg::COEFF_BITS-1:0];
        if (coef[cpk_pkg::COEF_W-1]) v = coef[cpk_pkg::COEFF_BITS-1:0] + mod_q;
        cnt = {2'b00, scnt[2:0]};
        sbuf = sbuf | (22'(v) << cnt);
        scnt = cnt + 5'd15;
        while (scnt >= 5'd8 && n < 2) begin
          burst[n] = '0;
          burst[n].byte_out = sbuf[7:0];
          sbuf = sbuf >> 8;
          scnt = scnt - 5'd8;
          n++;
        end
        burst[n-1].run_last = 1'b1;
        burst[n-1].poly_done = fin;
        for (int i = 0; i < n; i++) stream_results_q.push_back(burst[i]);
        if (fin) restart_stream();
        else nitems = nitems + 1'b1;
      end else begin
        cnt = (scnt > 5'd14) ? 5'd14 : scnt;
        sbuf = sbuf | (22'(bin) << cnt);
        scnt = cnt + 5'd8;
        if (scnt >= 5'd15) begin
          burst[0] = '0;
          burst[0].coeff_out = sbuf[cpk_pkg::COEFF_BITS-1:0];
          burst[0].run_last = 1'b1;
          burst[0].poly_done = fin;
          sbuf = sbuf >> cpk_pkg::COEFF_BITS;
          scnt = scnt - 5'd15;
          stream_results_q.push_back(burst[0]);
          if (fin) restart_stream();
          else nitems = nitems + 1'b1;
        end
      end
    end
  endtask

  task automatic report(input string msg);
    begin
      if (n_err < MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
      n_err++;
    end
  endtask

  function automatic int pick_gap();
    int r;
    begin
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 93) return $urandom_range(3, 8);
      return $urandom_range(20, 80);
    end
  endfunction

  function automatic logic signed [cpk_pkg::COEF_W-1:0] pick_coeff();
    int r;
    begin
      r = $urandom_range(0, 9);
      if (r < 4) return 16'($urandom);
      if (r < 6) return 16'($urandom_range(0, 32767));
      if (r < 8) return 16'(0 - $urandom_range(1, 16384));
      case ($urandom_range(0, 4))
        0: return 16'h8000;
        1: return 16'h7fff;
        2: return 16'hffff;
        3: return 16'h0000;
        default: return 16'(0 - int'(mod_q));
      endcase
    end
  endfunction

  function automatic logic [cpk_pkg::BYTE_W-1:0] pick_byte();
    int r;
    begin
      r = $urandom_range(0, 9);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hff;
      return 8'($urandom);
    end
  endfunction

  function automatic logic [cpk_pkg::COEFF_BITS-1:0] pick_modulus();
    case ($urandom_range(0, 5))
      0: return 15'd0;
      1: return 15'd1;
      2: return 15'h7fff;
      3: return cpk_pkg::MODULUS_RESET;
      default: return 15'($urandom);
    endcase
  endfunction

  task automatic queue_item(input logic signed [cpk_pkg::COEF_W-1:0] coef,
                            input logic [cpk_pkg::BYTE_W-1:0] bin);
    feed_t f;
    begin
      f.coef = coef;
      f.bin = bin;
      feed_q.push_back(f);
      n_items++;
    end
  endtask

  task automatic write_reg(input cpk_pkg::cfg_reg_e idx,
                           input logic [cpk_pkg::CFG_DATA_W-1:0] val);
    begin
      @(negedge clk);
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx;
      cfg_ch.data  <= val;
      do @(posedge clk); while (!cfg_ch.ready);
      if (idx == cpk_pkg::REG_MODULUS) begin
        mod_q = val;
      end else begin
        dir_q = cpk_pkg::dir_e'(val[0]);
        restart_stream();
      end
      n_cfg++;
      @(negedge clk);
      cfg_ch.valid <= 1'b0;
    end
  endtask

  // wait for all items and results, then let the pipeline run dry
  task automatic settle();
    begin
      while (feed_q.size() != 0 || in_ch.valid || stream_results_q.size() != 0)
        @(posedge clk);
      repeat (SETTLE_WAIT) @(posedge clk);
    end
  endtask

  // item driver
  always @(negedge clk) begin
    if (!in_ch.valid || in_fire) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_ch.valid <= 1'b0;
      end else if (feed_q.size() != 0) begin
        cur = feed_q.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.coefficient <= cur.coef;
        in_ch.byte_in     <= cur.bin;
        if (idle_on && $urandom_range(0, 3) == 0) tx_gap = pick_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver with random back-pressure
  always @(negedge clk) begin
    if (stall_req) begin
      stall_req = 1'b0;
      stall_left = STALL_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      rx_gap = pick_gap() - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk) begin
    in_fire = rst_ni && in_ch.valid && in_ch.ready;
    if (in_fire) begin
      if (dir_q == cpk_pkg::DIR_PACK) n_packed++;
      else n_unpacked++;
      advance_stream(in_ch.coefficient, in_ch.byte_in);
    end
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (out_ch.poly_done) n_done++;
      if (stream_results_q.size() == 0) begin
        report($sformatf("unexpected result byte %02h coeff %04h last %b done %b",
                         out_ch.byte_out, out_ch.coeff_out, out_ch.run_last,
                         out_ch.poly_done));
      end else begin
        want = stream_results_q.pop_front();
        if (out_ch.byte_out !== want.byte_out)
          report($sformatf("byte_out %02h, expected %02h", out_ch.byte_out, want.byte_out));
        if (out_ch.coeff_out !== want.coeff_out)
          report($sformatf("coeff_out %04h, expected %04h", out_ch.coeff_out,
                           want.coeff_out));
        if (out_ch.run_last !== want.run_last)
          report($sformatf("run_last %b, expected %b", out_ch.run_last, want.run_last));
        if (out_ch.poly_done !== want.poly_done)
          report($sformatf("poly_done %b, expected %b", out_ch.poly_done, want.poly_done));
      end
    end
    if (in_fire || (rst_ni && out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= WDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", quiet);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int len;
    in_ch.valid       = 1'b0;
    in_ch.coefficient = '0;
    in_ch.byte_in     = '0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = cpk_pkg::REG_MODULUS;
    cfg_ch.data       = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // reset configuration: pack with the default modulus
    queue_item(16'h0000, pick_byte());
    queue_item(16'h0001, pick_byte());
    queue_item(16'hffff, pick_byte());
    queue_item(16'h7fff, pick_byte());
    queue_item(16'h8000, pick_byte());
    queue_item(16'h4000, pick_byte());
    queue_item(16'(0 - 7681), pick_byte());
    queue_item(16'(0 - 7682), pick_byte());
    queue_item(16'h2aaa, pick_byte());
    queue_item(16'h5555, pick_byte());
    settle();

    // zero modulus, negative values wrap
    write_reg(cpk_pkg::REG_MODULUS, 15'd0);
    write_reg(cpk_pkg::REG_DIRECTION, {14'($urandom), cpk_pkg::DIR_PACK});
    queue_item(16'hffff, pick_byte());
    queue_item(16'h8000, pick_byte());
    queue_item(16'hc000, pick_byte());
    settle();

    // largest modulus, stream continues across the write
    write_reg(cpk_pkg::REG_MODULUS, 15'h7fff);
    queue_item(16'hffff, pick_byte());
    queue_item(16'h8000, pick_byte());
    queue_item(16'h0001, pick_byte());
    settle();

    // unpack, including bytes that complete nothing
    write_reg(cpk_pkg::REG_DIRECTION, {14'($urandom), cpk_pkg::DIR_UNPACK});
    queue_item(pick_coeff(), 8'h00);
    queue_item(pick_coeff(), 8'hff);
    queue_item(pick_coeff(), 8'hff);
    queue_item(pick_coeff(), 8'h80);
    queue_item(pick_coeff(), 8'h01);
    queue_item(pick_coeff(), 8'h7f);
    queue_item(pick_coeff(), 8'h55);
    queue_item(pick_coeff(), 8'haa);
    queue_item(pick_coeff(), 8'hfe);
    settle();

    // long receiver stall while the sender keeps offering
    write_reg(cpk_pkg::REG_DIRECTION, {14'($urandom), cpk_pkg::DIR_PACK});
    idle_on = 1'b1;
    stall_req = 1'b1;
    repeat (80) queue_item(pick_coeff(), pick_byte());
    settle();

    while (n_items < NUM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) write_reg(cpk_pkg::REG_MODULUS, pick_modulus());
      if ($urandom_range(0, 1) == 0) write_reg(cpk_pkg::REG_DIRECTION, 15'($urandom));
      idle_on = ($urandom_range(0, 3) != 0);
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : $urandom_range(20, 120);
      repeat (len) queue_item(pick_coeff(), pick_byte());
      settle();
    end

    $display("covered %0d coefficients packed, %0d bytes unpacked, %0d register writes",
             n_packed, n_unpacked, n_cfg);
    $display("checked %0d results with %0d polynomial ends, %0d mismatches",
             n_results, n_done, n_err);
    if (n_err == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
